// ===== rtl/gcyc_pkg.sv =====
package gcyc_pkg;

    // default sizing of the graph store
    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_DEPS_DEF  = 8;

    // fixed field widths of the ports
    localparam int IDX_W = 6;
    localparam int CFG_W = 7;

    // search colours
    typedef enum logic [1:0] {
        COL_WHITE = 2'd0,
        COL_GREY  = 2'd1,
        COL_BLACK = 2'd2
    } colour_t;

endpackage

// ===== rtl/graph_cycle_detector.sv =====
// channel   direction  handshake              word
// --------  ---------  ---------------------  ----------------------------------------
// input     in         in_valid / in_stall    node_index, dep_index, has_dep, last
// output    out        out_valid / out_stall  has_cycle, dropped
// config    in         cfg_valid / cfg_ready  graph_size
//
// an item without an edge, or with its node outside the graph, is taken in S_IDLE alone
// an item with an edge for a node in the graph goes on to S_LOAD (count read, then write)
// search: a start node passes S_START, S_START_CHK; an edge S_SCAN, S_EDGE, S_COLOUR (a dep
// outside the graph skips S_COLOUR); a pop S_SCAN, then S_POP but for the last; reads registered
// after reset and after each answer a clearing pass over all MAX_NODES nodes wipes counts and colours
// the result sits in an output register; a stalled result holds the next answer back only
module graph_cycle_detector
    import gcyc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_DEPS  = MAX_DEPS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] graph_size,
    // edge words
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [IDX_W-1:0] node_index,
    input  logic [IDX_W-1:0] dep_index,
    input  logic             has_dep,
    input  logic             last,
    // answer words
    output logic             out_valid,
    input  logic             out_stall,
    output logic             has_cycle,
    output logic             dropped
);

    // widths that follow from the sizing
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int EW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int DEP_W  = $clog2(MAX_DEPS + 1);
    localparam int EDGES  = MAX_NODES * MAX_DEPS;
    localparam int AW     = $clog2(EDGES);
    localparam int NW     = DEP_W + 2;
    localparam int SW     = NODE_W + 2 * DEP_W;

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b00_0000_0001,
        S_IDLE      = 10'b00_0000_0010,
        S_LOAD      = 10'b00_0000_0100,
        S_START     = 10'b00_0000_1000,
        S_START_CHK = 10'b00_0001_0000,
        S_SCAN      = 10'b00_0010_0000,
        S_EDGE      = 10'b00_0100_0000,
        S_COLOUR    = 10'b00_1000_0000,
        S_POP       = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } state_t;

    // memories: per node {dep count, colour}, dependency lists, search stack
    logic [NW-1:0]    node_mem  [MAX_NODES];
    logic [IDX_W-1:0] edge_mem  [EDGES];
    logic [SW-1:0]    stack_mem [MAX_NODES];

    logic              nm_we;
    logic [NODE_W-1:0] nm_waddr;
    logic [NW-1:0]     nm_wdata;
    logic [NODE_W-1:0] nm_raddr;
    logic [NW-1:0]     nm_rdata;
    logic              em_we;
    logic [AW-1:0]     em_waddr;
    logic [IDX_W-1:0]  em_wdata;
    logic [AW-1:0]     em_raddr;
    logic [IDX_W-1:0]  em_rdata;
    logic              sm_we;
    logic [NODE_W-1:0] sm_waddr;
    logic [SW-1:0]     sm_wdata;
    logic [NODE_W-1:0] sm_raddr;
    logic [SW-1:0]     sm_rdata;

    // control state
    state_t            state_reg, state_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic [CFG_W-1:0]  graph_size_reg;
    logic              drop_reg, drop_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    // working registers
    logic [EW-1:0]     n_reg, n_next;
    logic [EW-1:0]     start_reg, start_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [DEP_W-1:0]  nd_reg, nd_next;
    logic [DEP_W-1:0]  cnt_reg, cnt_next;
    logic [NODE_W-1:0] d_reg, d_next;
    logic [NODE_W-1:0] ld_node_reg, ld_node_next;
    logic [IDX_W-1:0]  ld_dep_reg, ld_dep_next;
    logic              ld_last_reg, ld_last_next;
    logic              has_cycle_reg, has_cycle_next;
    logic              dropped_reg, dropped_next;

    // helpers
    logic [EW-1:0]     eff_count;
    logic [EW-1:0]     node_ext;
    logic [EW-1:0]     d_ext;
    logic              accept;
    colour_t           rd_colour;
    logic [DEP_W-1:0]  rd_count;
    logic [NODE_W-1:0] stk_node;
    logic [DEP_W-1:0]  stk_nd;
    logic [DEP_W-1:0]  stk_cnt;

    assign eff_count = (EW'(graph_size_reg) > EW'(MAX_NODES)) ? EW'(MAX_NODES)
                                                             : EW'(graph_size_reg);
    assign node_ext  = EW'(node_index);
    assign d_ext     = EW'(em_rdata);
    assign accept    = in_valid && !in_stall;
    assign rd_colour = colour_t'(nm_rdata[1:0]);
    assign rd_count  = nm_rdata[NW-1:2];
    assign {stk_node, stk_nd, stk_cnt} = sm_rdata;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign has_cycle = has_cycle_reg;
    assign dropped   = dropped_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        depth_next     = depth_reg;
        drop_next      = drop_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && out_stall;
        n_next         = n_reg;
        start_next     = start_reg;
        cur_next       = cur_reg;
        nd_next        = nd_reg;
        cnt_next       = cnt_reg;
        d_next         = d_reg;
        ld_node_next   = ld_node_reg;
        ld_dep_next    = ld_dep_reg;
        ld_last_next   = ld_last_reg;
        has_cycle_next = has_cycle_reg;
        dropped_next   = dropped_reg;

        nm_we    = 1'b0;
        nm_waddr = cur_reg;
        nm_wdata = '0;
        nm_raddr = cur_reg;
        em_we    = 1'b0;
        em_waddr = AW'(ld_node_reg) * AW'(MAX_DEPS) + AW'(rd_count);
        em_wdata = ld_dep_reg;
        em_raddr = AW'(cur_reg) * AW'(MAX_DEPS) + AW'(nd_reg);
        sm_we    = 1'b0;
        sm_waddr = depth_reg[NODE_W-1:0] - NODE_W'(1);
        sm_wdata = {cur_reg, nd_reg, cnt_reg};
        sm_raddr = depth_reg[NODE_W-1:0] - NODE_W'(2);

        case (state_reg)
            // wipe counts and colours, one node a cycle
            S_CLEAR:
            begin
                nm_we    = 1'b1;
                nm_waddr = clr_reg;
                nm_wdata = '0;
                if (clr_reg == NODE_W'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + NODE_W'(1);
                end
            end

            S_IDLE:
            begin
                nm_raddr = node_ext[NODE_W-1:0];
                if (accept)
                begin
                    n_next       = eff_count;
                    start_next   = '0;
                    ld_node_next = node_ext[NODE_W-1:0];
                    ld_dep_next  = dep_index;
                    ld_last_next = last;
                    if (has_dep && (node_ext < eff_count))
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        if (has_dep)
                        begin
                            drop_next = 1'b1;
                        end
                        if (last)
                        begin
                            state_next = S_START;
                        end
                    end
                end
            end

            // count of the node is in, append or drop on a full list
            S_LOAD:
            begin
                if (rd_count >= DEP_W'(MAX_DEPS))
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    em_we    = 1'b1;
                    nm_we    = 1'b1;
                    nm_waddr = ld_node_reg;
                    nm_wdata = {rd_count + DEP_W'(1), nm_rdata[1:0]};
                end
                state_next = ld_last_reg ? S_START : S_IDLE;
            end

            S_START:
            begin
                nm_raddr = start_reg[NODE_W-1:0];
                if (start_reg == n_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_START_CHK;
                end
            end

            S_START_CHK:
            begin
                if (rd_colour != COL_WHITE)
                begin
                    start_next = start_reg + EW'(1);
                    state_next = S_START;
                end
                else
                begin
                    nm_we      = 1'b1;
                    nm_waddr   = start_reg[NODE_W-1:0];
                    nm_wdata   = {rd_count, COL_GREY};
                    cur_next   = start_reg[NODE_W-1:0];
                    nd_next    = '0;
                    cnt_next   = rd_count;
                    depth_next = CNT_W'(1);
                    state_next = S_SCAN;
                end
            end

            // next dependency of the top node, or retire it
            S_SCAN:
            begin
                if (nd_reg < cnt_reg)
                begin
                    nd_next    = nd_reg + DEP_W'(1);
                    state_next = S_EDGE;
                end
                else
                begin
                    nm_we      = 1'b1;
                    nm_waddr   = cur_reg;
                    nm_wdata   = {cnt_reg, COL_BLACK};
                    depth_next = depth_reg - CNT_W'(1);
                    if (depth_reg == CNT_W'(1))
                    begin
                        start_next = start_reg + EW'(1);
                        state_next = S_START;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end

            // dependencies outside the graph are skipped
            S_EDGE:
            begin
                d_next   = d_ext[NODE_W-1:0];
                nm_raddr = d_ext[NODE_W-1:0];
                if (d_ext >= n_reg)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_COLOUR;
                end
            end

            S_COLOUR:
            begin
                state_next = S_SCAN;
                if (rd_colour == COL_GREY)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if ((rd_colour == COL_WHITE) && (depth_reg < CNT_W'(MAX_NODES)))
                begin
                    nm_we      = 1'b1;
                    nm_waddr   = d_reg;
                    nm_wdata   = {rd_count, COL_GREY};
                    sm_we      = 1'b1;
                    cur_next   = d_reg;
                    nd_next    = '0;
                    cnt_next   = rd_count;
                    depth_next = depth_reg + CNT_W'(1);
                end
            end

            // parent frame back from the stack
            S_POP:
            begin
                cur_next   = stk_node;
                nd_next    = stk_nd;
                cnt_next   = stk_cnt;
                state_next = S_SCAN;
            end

            // hand the answer over once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    has_cycle_next = found_reg;
                    dropped_next   = drop_reg;
                    found_next     = 1'b0;
                    drop_next      = 1'b0;
                    depth_next     = '0;
                    clr_next       = '0;
                    state_next     = S_CLEAR;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            depth_reg      <= '0;
            drop_reg       <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            graph_size_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            depth_reg     <= depth_next;
            drop_reg      <= drop_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                graph_size_reg <= graph_size;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        start_reg     <= start_next;
        cur_reg       <= cur_next;
        nd_reg        <= nd_next;
        cnt_reg       <= cnt_next;
        d_reg         <= d_next;
        ld_node_reg   <= ld_node_next;
        ld_dep_reg    <= ld_dep_next;
        ld_last_reg   <= ld_last_next;
        has_cycle_reg <= has_cycle_next;
        dropped_reg   <= dropped_next;
    end

    // node memory
    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            node_mem[nm_waddr] <= nm_wdata;
        end
        nm_rdata <= node_mem[nm_raddr];
    end

    // edge memory
    always_ff @(posedge clk)
    begin
        if (em_we)
        begin
            edge_mem[em_waddr] <= em_wdata;
        end
        em_rdata <= edge_mem[em_raddr];
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            stack_mem[sm_waddr] <= sm_wdata;
        end
        sm_rdata <= stack_mem[sm_raddr];
    end

endmodule
